### design/lkvc_pkg.sv
// Shared constants for the LRU key-value cache.
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT   = 16;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Capacity register: width and reset value
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   // Width of the read value on the response port
   localparam int READ_W = 32;

   // Request codes
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

endpackage

### design/lkvc_cell.sv
// One entry of the recency-ordered cell chain: key, value, valid and key match.
module lkvc_cell #(
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  up_valid,
   input  logic [KEY_BITS-1:0]   up_key,
   input  logic [VALUE_BITS-1:0] up_value,
   input  logic [KEY_BITS-1:0]   lookup_key,
   output logic                  valid,
   output logic [KEY_BITS-1:0]   key,
   output logic [VALUE_BITS-1:0] value,
   output logic                  match
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [KEY_BITS-1:0]   key_ff;
   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   // Take the upstream neighbor's entry on a shift, otherwise hold
   always_comb begin
      valid_in = shift_en ? up_valid : valid_ff;
      key_in   = shift_en ? up_key   : key_ff;
      value_in = shift_en ? up_value : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;
   assign match = valid_ff && (key_ff == lookup_key);

endmodule

### design/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Flow: an accepted request is held in the request register, the compare pass
// registers its match results, and the update pass shifts the chain and loads
// the response register once the response slot is free. A new request is taken
// while idle or as the previous one commits; a stalled response holds the shift pass.
// Reset: empties the store, clears the fill count and sets capacity to 16.
module lru_key_value_cache #(
   parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [KEY_BITS-1:0]         req_key,
   input  logic [VALUE_BITS-1:0]       req_write_value,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [lkvc_pkg::READ_W-1:0] rsp_read_value,
   output logic                        rsp_evicted,
   // capacity register
   input  logic                        csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]  csr_wr_data
);

   localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request
   localparam logic [1:0] ST_CMP  = 2'd1;  // all cells compare the key
   localparam logic [1:0] ST_UPD  = 2'd2;  // shift the chain, load the response

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Request holding register
   logic                  req_type_ff;
   logic [KEY_BITS-1:0]   req_key_ff;
   logic [VALUE_BITS-1:0] req_value_ff;

   // Compare results, captured at the end of the compare cycle
   logic                  hit_ff;
   logic [PTR_W-1:0]      hit_pos_ff;
   logic [VALUE_BITS-1:0] hit_value_ff;
   logic [PTR_W-1:0]      hit_pos_in;
   logic [VALUE_BITS-1:0] hit_value_in;

   // Fill count and capacity register
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [lkvc_pkg::CAP_W-1:0] capacity_ff;

   // Response register
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [lkvc_pkg::READ_W-1:0] rsp_read_value_ff;
   logic                        rsp_evicted_ff;

   // Cell chain wiring
   logic [ENTRIES-1:0]    cell_valid;
   logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0] cell_value [ENTRIES];
   logic [ENTRIES-1:0]    cell_match;
   logic [ENTRIES-1:0]    cell_shift;

   // Update-cycle control
   logic                  out_free;
   logic                  commit;
   logic                  is_put;
   logic                  chain_write;
   logic                  evict;
   logic [PTR_W-1:0]      move_pos;
   logic [VALUE_BITS-1:0] front_value;
   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      eff_cap;
   logic [CMP_W-1:0]      count_ext;

   //--------------------------------------------------------------------------
   // Handshake. A new request may be taken in the same cycle that the previous
   // one commits, so the next compare already sees the shifted chain.
   //--------------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_UPD) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            // hold here while the response register is still occupied
            if (commit) begin
               state_in = req_valid ? ST_CMP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request on each transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_type_ff  <= req_type;
         req_key_ff   <= req_key;
         req_value_ff <= req_write_value;
      end
   end

   //--------------------------------------------------------------------------
   // Compare pass: keys are unique among valid cells, so at most one match;
   // OR-reduce its position and value.
   //--------------------------------------------------------------------------
   always_comb begin
      hit_pos_in   = '0;
      hit_value_in = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_match[i]) begin
            hit_pos_in   = hit_pos_in | PTR_W'(i);
            hit_value_in = hit_value_in | cell_value[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP) begin
         hit_ff       <= |cell_match;
         hit_pos_ff   <= hit_pos_in;
         hit_value_ff <= hit_value_in;
      end
   end

   //--------------------------------------------------------------------------
   // Update pass. The chain is ordered by recency, cell 0 most recent and the
   // valid cells forming a prefix. Every change is a move to front: cells
   // 0..move_pos take their upstream neighbor and cell 0 takes the entry.
   //   hit:            move_pos is the matching cell
   //   miss, evicting: move_pos is the last valid cell, which drops off
   //   miss, room:     move_pos is the first free cell
   //--------------------------------------------------------------------------
   assign is_put    = (req_type_ff == lkvc_pkg::REQ_PUT);
   assign cap_ext   = CMP_W'(capacity_ff);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      // zero capacity behaves as one, anything beyond the chain as full size
      priority if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict       = is_put && !hit_ff && (count_ext >= eff_cap);
   assign chain_write = commit && (is_put || hit_ff);
   assign front_value = is_put ? req_value_ff : hit_value_ff;

   always_comb begin
      priority if (hit_ff) begin
         move_pos = hit_pos_ff;
      end else if (evict) begin
         move_pos = PTR_W'(count_ff - CNT_W'(1));
      end else begin
         move_pos = PTR_W'(count_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         cell_shift[i] = chain_write && (PTR_W'(i) <= move_pos);
      end
   end

   // A put of a new key grows the store unless it evicted
   always_comb begin
      count_in = count_ff;
      if (commit && is_put && !hit_ff && !evict) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         capacity_ff <= lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   //--------------------------------------------------------------------------
   // Cell chain
   //--------------------------------------------------------------------------
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic                  up_valid;
      logic [KEY_BITS-1:0]   up_key;
      logic [VALUE_BITS-1:0] up_value;

      if (g == 0) begin : g_head
         assign up_valid = 1'b1;
         assign up_key   = req_key_ff;
         assign up_value = front_value;
      end else begin : g_link
         assign up_valid = cell_valid[g-1];
         assign up_key   = cell_key[g-1];
         assign up_value = cell_value[g-1];
      end

      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (cell_shift[g]),
         .up_valid   (up_valid),
         .up_key     (up_key),
         .up_value   (up_value),
         .lookup_key (req_key_ff),
         .valid      (cell_valid[g]),
         .key        (cell_key[g]),
         .value      (cell_value[g]),
         .match      (cell_match[g])
      );
   end

   //--------------------------------------------------------------------------
   // Response register: load on commit, drop on transfer
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff        <= hit_ff;
         rsp_read_value_ff <= (!is_put && hit_ff) ?
                              lkvc_pkg::READ_W'(hit_value_ff) : '0;
         rsp_evicted_ff    <= evict;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   //--------------------------------------------------------------------------
   // Assertions
   //--------------------------------------------------------------------------
   logic [ENTRIES-1:0] fill_mask;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         fill_mask[i] = (CNT_W'(i) < count_ff);
      end
   end

   // valid cells always form a prefix as long as the fill count
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      cell_valid == fill_mask)
      else $error("valid cells do not match the fill count");

   // keys stay unique, so a lookup matches at most one cell
   a_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_match))
      else $error("key present in more than one cell");

   // an eviction only comes from a put that missed
   a_evict: assert property (@(posedge clock) disable iff (reset)
      commit && evict |=> rsp_valid && rsp_evicted && !rsp_hit)
      else $error("eviction reported with a hit");

   // the fill count never grows past the chain
   a_count: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(ENTRIES))
      else $error("fill count beyond the number of cells");

endmodule

### bench/tb_lru_key_value_cache.sv
// Testbench for the LRU key-value cache: directed and random traffic checked by a predictor.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

   localparam int KEY_W       = lkvc_pkg::KEY_BITS_DEFAULT;
   localparam int VAL_W       = lkvc_pkg::VALUE_BITS_DEFAULT;
   localparam int SLOTS       = lkvc_pkg::ENTRIES_DEFAULT;
   localparam int RD_W        = lkvc_pkg::READ_W;
   localparam int CAP_W       = lkvc_pkg::CAP_W;
   localparam int POOL_SIZE   = 24;
   localparam int DRAIN_PAUSE = 6;
   localparam int CYCLE_LIMIT = 200000;

   // One line of the cache as the predictor keeps it
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } cache_line_type;

   // One response as the block should return it
   typedef struct packed {
      logic            hit;
      logic [RD_W-1:0] read_value;
      logic            evicted;
   } cache_rsp_type;

   logic                clock;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic                req_type        = lkvc_pkg::REQ_GET;
   logic [KEY_W-1:0]    req_key         = '0;
   logic [VAL_W-1:0]    req_write_value = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic                rsp_hit;
   logic [RD_W-1:0]     rsp_read_value;
   logic                rsp_evicted;
   logic                csr_wr_en       = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data     = '0;

   // Predictor state: lines ordered from most recent (index 0) to least recent
   cache_line_type      recency_list[$];
   logic [CAP_W-1:0]    capacity_reg;

   // Responses predicted but not yet seen on the response port
   cache_rsp_type       pending_rsp[$];

   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  error_count   = 0;
   int                  cycle_count   = 0;
   int                  get_count     = 0;
   int                  put_count     = 0;
   int                  hit_count     = 0;
   int                  evict_count   = 0;
   int                  rsp_count     = 0;
   int                  cap_writes    = 0;

   lru_key_value_cache u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Free-running clock, 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stop a hung run; the limit is many times the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_rsp.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side back-pressure: drop ready on a share of the cycles
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Print one mismatch line and count it
   task automatic flag_error(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   // Capacity as the block applies it: zero acts as one, large values clamp
   function automatic int effective_capacity();
      int c;
      c = int'(capacity_reg);
      if (c == 0) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
   endfunction

   // Apply one request to the predictor and return the response it implies
   function automatic cache_rsp_type predict_access(input logic             op,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [VAL_W-1:0] v);
      cache_rsp_type  r;
      cache_line_type line;
      int             pos;
      r   = '0;
      pos = -1;
      foreach (recency_list[i])
         if (recency_list[i].key == k) pos = i;

      if (pos >= 0) begin
         // Present key: the line moves to the front either way
         r.hit = 1'b1;
         line  = recency_list[pos];
         if (op == lkvc_pkg::REQ_PUT) line.value = v;
         else r.read_value = line.value;
         recency_list.delete(pos);
         recency_list.push_front(line);
      end else if (op == lkvc_pkg::REQ_PUT) begin
         // New key: when full (or over a lowered capacity) drop the oldest line
         if (recency_list.size() >= effective_capacity()) begin
            recency_list.delete(recency_list.size() - 1);
            r.evicted = 1'b1;
         end
         line.key   = k;
         line.value = v;
         recency_list.push_front(line);
      end

      if (op == lkvc_pkg::REQ_PUT) put_count++;
      else get_count++;
      if (r.hit) hit_count++;
      if (r.evicted) evict_count++;
      return r;
   endfunction

   // Check every response transfer against the oldest prediction
   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_hit !== want.hit)
               flag_error($sformatf("hit %b, predicted %b", rsp_hit, want.hit));
            if (rsp_read_value !== want.read_value)
               flag_error($sformatf("read_value %h, predicted %h",
                                    rsp_read_value, want.read_value));
            if (rsp_evicted !== want.evicted)
               flag_error($sformatf("evicted %b, predicted %b",
                                    rsp_evicted, want.evicted));
         end
      end
   end

   // Send one request: optional idle gap, then hold valid until the transfer.
   // Valid is left high afterwards; an idle gap in the next call or the drain lowers it.
   task automatic send_request(input logic             op,
                               input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= op;
      req_key         <= k;
      req_write_value <= v;
      pending_rsp.push_back(predict_access(op, k, v));
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Write the capacity register; call only with the block idle
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_responses();
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= cap;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      capacity_reg  = cap;
      cap_writes++;
      @(posedge clock);
   endtask

   // Misses on an empty store, extreme keys and values, update in place
   task automatic test_get_put_extremes();
      send_request(lkvc_pkg::REQ_GET, '0, '0);
      send_request(lkvc_pkg::REQ_GET, '1, '1);          // get ignores write_value
      send_request(lkvc_pkg::REQ_PUT, '0, '1);
      send_request(lkvc_pkg::REQ_PUT, '1, '0);
      send_request(lkvc_pkg::REQ_GET, '0, 32'h5555_AAAA);
      send_request(lkvc_pkg::REQ_GET, '1, '0);
      send_request(lkvc_pkg::REQ_PUT, '0, '0);          // overwrite a present key
      send_request(lkvc_pkg::REQ_GET, '0, '0);
   endtask

   // Eviction of the least recent line, and a put to a present key when full
   task automatic test_lru_replacement();
      write_capacity(5'd2);
      send_request(lkvc_pkg::REQ_PUT, 16'h1234, 32'hDEAD_BEEF);  // evicts the oldest line
      send_request(lkvc_pkg::REQ_GET, '1, '0);
      send_request(lkvc_pkg::REQ_PUT, '0, 32'h0000_0001);        // full, present: no eviction
      send_request(lkvc_pkg::REQ_PUT, 16'h4321, 32'h8000_0000);
      send_request(lkvc_pkg::REQ_GET, 16'h1234, '0);
      send_request(lkvc_pkg::REQ_GET, '0, '0);
   endtask

   // Capacity zero acts as one; lowering below occupancy flushes nothing at once
   task automatic test_capacity_floor();
      write_capacity(5'd0);
      send_request(lkvc_pkg::REQ_PUT, 16'hA5A5, 32'hA5A5_A5A5);
      send_request(lkvc_pkg::REQ_PUT, 16'h5A5A, 32'h5A5A_5A5A);
      send_request(lkvc_pkg::REQ_GET, 16'hA5A5, '0);
      send_request(lkvc_pkg::REQ_GET, '0, '0);
   endtask

   // Capacity values above the slot count clamp to the slot count
   task automatic test_capacity_ceiling();
      write_capacity(5'd31);
      send_request(lkvc_pkg::REQ_PUT, 16'h0F0F, 32'h0F0F_0F0F);
      send_request(lkvc_pkg::REQ_PUT, 16'hF0F0, 32'hF0F0_F0F0);
      write_capacity(5'd17);
      send_request(lkvc_pkg::REQ_PUT, 16'h7FFF, 32'h7FFF_FFFF);
      send_request(lkvc_pkg::REQ_GET, 16'h5A5A, '0);
   endtask

   // Random gets and puts over a key pool a little larger than the capacity,
   // so that hits, misses and evictions all stay frequent
   task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int n_items);
      logic [KEY_W-1:0] key_pool[POOL_SIZE];
      logic [KEY_W-1:0] k;
      logic             op;
      int               span;
      write_capacity(cap);
      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(65535));
      span = effective_capacity() + 6;
      if (span > POOL_SIZE) span = POOL_SIZE;
      repeat (n_items) begin
         op = ($urandom_range(99) < 50) ? lkvc_pkg::REQ_PUT : lkvc_pkg::REQ_GET;
         if ($urandom_range(99) < 8) k = KEY_W'($urandom);
         else k = key_pool[$urandom_range(span - 1)];
         send_request(op, k, VAL_W'($urandom));
      end
   endtask

   initial begin
      // Hold reset at the start, then start from an empty store
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      recency_list.delete();
      capacity_reg = 5'(lkvc_pkg::CAP_RESET);
      @(posedge clock);

      // Sender mostly busy, receiver mostly stalling
      send_idle_pct = 22;
      recv_idle_pct = 68;
      test_get_put_extremes();
      test_lru_replacement();
      test_capacity_floor();
      test_capacity_ceiling();
      test_random_traffic(5'd4, 180);
      test_random_traffic(5'd16, 120);

      // Swap the roles: sender gappy, receiver mostly ready
      drain_responses();
      send_idle_pct = 68;
      recv_idle_pct = 22;
      test_random_traffic(5'd1, 100);
      test_random_traffic(5'd31, 120);

      // Full rate on both sides
      drain_responses();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(5'd9, 180);

      drain_responses();
      $display("Covered %0d gets (%0d hits total) and %0d puts with %0d evictions",
               get_count, hit_count, put_count, evict_count);
      $display("%0d responses checked across %0d capacity writes and three stall mixes",
               rsp_count, cap_writes);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
